// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define NBD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define NBD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbd assertion failed");

`endif

// ===== hw/rtl/nbd_pkg.sv =====
package nbd_pkg;

  localparam int FIELD_W = 20;
  localparam int CELL_W = 12;
  localparam int COUNT_OUT_W = 7;
  localparam int MAX_BOXES_DEF = 64;
  localparam int FRAC_BITS_DEF = 8;
  localparam logic [FIELD_W-1:0] DIST_SAT = '1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_DRAIN,
    S_ROOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] front_x;
    logic [FIELD_W-1:0] centre_y;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
  } box_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [FIELD_W-1:0] box_front_x;
    logic [FIELD_W-1:0] box_centre_y;
    logic [FIELD_W-1:0] box_length;
    logic [FIELD_W-1:0] box_width;
    logic [FIELD_W-1:0] box_height;
    logic [CELL_W-1:0]  cell_i;
    logic [CELL_W-1:0]  cell_j;
    logic [CELL_W-1:0]  cell_k;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]     min_distance;
    logic                   table_empty;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] entries_held;
  } out_item_t;

  // Cell centre coordinate width in half-LSB units.
  function automatic int nbd_cw(input int frac);
    return CELL_W + frac + 1;
  endfunction

  // Signed working width for coordinates and differences.
  function automatic int nbd_vw(input int frac);
    int c;
    c = nbd_cw(frac);
    return ((c > FIELD_W + 2) ? c : FIELD_W + 2) + 2;
  endfunction

  // Width of a sum of up to three squared magnitudes.
  function automatic int nbd_sw(input int frac);
    return 2 * (nbd_vw(frac) - 1) + 2;
  endfunction

endpackage

// ===== hw/rtl/nbd_stream_if.sv =====
interface nbd_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nearest_box_distance_top.sv =====
// Append, clear and unused ops, and a query on an empty table: result registered on accept.
// Query: the walk of the building memory at one entry per cycle, then the CW-cell
// square-root row on the running minimum.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous reset empties the table and clears control; no memory clearing pass.
`include "assert_macros.svh"

module nearest_box_distance_top
  import nbd_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  nbd_stream_if.sink        req,
  nbd_stream_if.source      rsp
);

  localparam int CW = nbd_cw(FRAC_BITS);
  localparam int SW = nbd_sw(FRAC_BITS);
  localparam int RW = 2 * CW;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int NW = $clog2(MAX_BOXES + 1);

  in_item_t  item;
  out_item_t res, res_next;
  logic      res_valid, res_load;

  state_t state, state_next;
  logic [NW-1:0] count;
  logic [AW-1:0] addr;
  logic [CW-1:0] qi, qj, qk;
  logic [RW-1:0] kk;
  logic [SW-1:0] best;
  logic [CW-1:0] root;

  box_t mem [MAX_BOXES];
  box_t mem_q;
  logic rd_valid;

  logic          acc, app_ok, table_is_full;
  logic          f_valid, f_busy;
  logic [SW-1:0] f_dist;
  logic          sq_start, sq_valid;
  logic [RW-1:0] sq_rad;
  logic [CW-1:0] sq_root;
  logic [63:0]   half;

  assign item = req.data;
  assign req.ready = (state == S_IDLE) && (!res_valid || rsp.ready);
  assign acc = req.valid && req.ready;
  assign table_is_full = count >= NW'(MAX_BOXES);
  assign app_ok = acc && item.op == OP_APPEND && !table_is_full;

  assign half = 64'(root) >> 1;

  always_comb begin
    state_next = state;
    res_load = 1'b0;
    res_next = '0;
    res_next.entries_held = COUNT_OUT_W'(count);
    sq_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          res_load = 1'b1;
          case (item.op)
            OP_CLEAR: begin
              res_next.entries_held = '0;
            end
            OP_APPEND: begin
              res_next.table_full = table_is_full;
              if (!table_is_full) begin
                res_next.entries_held = COUNT_OUT_W'(count + NW'(1));
              end
            end
            OP_QUERY: begin
              if (count == '0) begin
                res_next.min_distance = DIST_SAT;
                res_next.table_empty = 1'b1;
              end else begin
                res_load = 1'b0;
                state_next = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: state_next = S_WALK;
      S_WALK: begin
        if (addr == AW'(count - NW'(1))) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_valid && !f_busy) begin
          sq_start = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq_valid) state_next = S_DONE;
      end
      S_DONE: begin
        if (!res_valid || rsp.ready) begin
          res_load = 1'b1;
          res_next.min_distance = (half > 64'(DIST_SAT)) ? DIST_SAT : half[FIELD_W-1:0];
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_valid <= (state == S_WALK);
      if (acc && item.op == OP_CLEAR) begin
        count <= '0;
      end else if (app_ok) begin
        count <= count + NW'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Query registers, walk address and running minimum of squared distances.
  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
    if (acc) begin
      qi <= (CW'(item.cell_i) << (FRAC_BITS + 1)) | CW'(1 << FRAC_BITS);
      qj <= (CW'(item.cell_j) << (FRAC_BITS + 1)) | CW'(1 << FRAC_BITS);
      qk <= (CW'(item.cell_k) << (FRAC_BITS + 1)) | CW'(1 << FRAC_BITS);
    end
    if (state == S_LOAD) begin
      kk   <= RW'(qk) * RW'(qk);
      best <= '1;
      addr <= '0;
    end else if (state == S_WALK) begin
      addr <= addr + AW'(1);
    end
    if (f_valid && f_dist < best) best <= f_dist;
    if (sq_valid) root <= sq_root;
  end

  always_ff @(posedge clk) begin
    if (app_ok) begin
      mem[count[AW-1:0]] <= '{item.box_front_x, item.box_centre_y, item.box_length,
                              item.box_width, item.box_height};
    end
    if (state == S_WALK) mem_q <= mem[addr];
  end

  // Clamping the squared minimum to the squared cell height clamps the root.
  assign sq_rad = (best < SW'(kk)) ? best[RW-1:0] : kk;

  nbd_face_unit #(.FRAC_BITS(FRAC_BITS), .CW(CW), .SW(SW)) u_face (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .box       (mem_q),
    .ic        (qi),
    .jc        (qj),
    .kc        (qk),
    .out_valid (f_valid),
    .out_dist  (f_dist),
    .busy      (f_busy)
  );

  nbd_sqrt_chain #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_start),
    .in_rad    (sq_rad),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  assign rsp.valid = res_valid;
  assign rsp.data  = res;

  `NBD_ASSERT_IMPL(a_count_bound, 1'b1, count <= NW'(MAX_BOXES))
  `NBD_ASSERT_NEXT(a_append_grows, app_ok, count == $past(count) + NW'(1))
  `NBD_ASSERT_IMPL(a_root_in_state, sq_valid, state == S_ROOT)

endmodule

// ===== hw/rtl/nbd_face_unit.sv =====
module nbd_face_unit
  import nbd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CW = nbd_cw(FRAC_BITS),
  parameter int SW = nbd_sw(FRAC_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  box_t          box,
  input  logic [CW-1:0] ic,
  input  logic [CW-1:0] jc,
  input  logic [CW-1:0] kc,
  output logic          out_valid,
  output logic [SW-1:0] out_dist,
  output logic          busy
);

  localparam int VW = nbd_vw(FRAC_BITS);
  localparam int MW = VW - 1;
  localparam int QW = 2 * MW;
  localparam logic [VW-1:0] FMASK = ~((VW'(1) << (FRAC_BITS + 1)) - VW'(1));

  // Truncate toward zero to a whole cell.
  function automatic logic signed [VW-1:0] whole(input logic signed [VW-1:0] v);
    logic [VW-1:0] m;
    m = (v < 0) ? VW'(-v) : VW'(v);
    m = m & FMASK;
    return (v < 0) ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = (v < 0) ? -v : v;
    return t[MW-1:0];
  endfunction

  // a when a lies strictly nearer to c than b, else b.
  function automatic logic signed [VW-1:0] nearer(input logic signed [VW-1:0] c,
                                                  input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
    return (mag(a - c) < mag(b - c)) ? a : b;
  endfunction

  logic signed [VW-1:0] ics, jcs, kcs;
  assign ics = signed'(VW'(ic));
  assign jcs = signed'(VW'(jc));
  assign kcs = signed'(VW'(kc));

  logic [6:0] vld;

  // Stage 1: face positions and whole-cell edges.
  logic signed [VW-1:0] x2, xl, yl, yh, h2, ex1, ex2, ey1, ey2;
  logic signed [VW-1:0] yc_w, xl_w, yl_w, yh_w, x2_w;
  assign x2_w = signed'(VW'({box.front_x, 1'b0}));
  assign xl_w = x2_w + signed'(VW'({box.length, 1'b0}));
  assign yc_w = signed'(VW'({box.centre_y, 1'b0}));
  assign yl_w = yc_w - signed'(VW'(box.width));
  assign yh_w = yc_w + signed'(VW'(box.width));

  always_ff @(posedge clk) begin
    x2  <= x2_w;
    xl  <= xl_w;
    yl  <= yl_w;
    yh  <= yh_w;
    h2  <= signed'(VW'({box.height, 1'b0}));
    ex1 <= whole(x2_w);
    ex2 <= whole(xl_w);
    ey1 <= whole(yl_w);
    ey2 <= whole(yh_w);
  end

  // Stage 2: nearest edge points for each face and for the roof.
  logic signed [VW-1:0] ie_f, ie_b, je_s, ie_r, je_r;
  logic signed [VW-1:0] x2_2, xl_2, yl_2, yh_2, h2_2;
  logic                 below2;
  logic signed [VW-1:0] ie_rw, je_rw;

  always_comb begin
    ie_rw = jcs;
    je_rw = ics;
    if (ics < ex1 || ics > ex2 || jcs < ey1 || jcs > ey2) begin
      if (ics <= ex1) begin
        je_rw = ex1;
        if (jcs < ey1) ie_rw = ey1;
        if (jcs > ey2) ie_rw = ey2;
      end
      if (ics >= ex2) begin
        je_rw = ex2;
        if (jcs <= ey1) ie_rw = ey1;
        if (jcs > ey2) ie_rw = ey2;
      end
      if (ics > ex1 && ics < ex2) begin
        je_rw = ics;
        if (jcs <= ey1) ie_rw = ey1;
        if (jcs > ey2) ie_rw = ey2;
      end
    end
  end

  always_ff @(posedge clk) begin
    ie_f <= (jcs <= ey1 || jcs >= ey2) ? nearer(jcs, ey2, ey1) : jcs;
    ie_b <= (jcs < ey1 || jcs > ey2) ? nearer(jcs, ey2, ey1) : jcs;
    je_s <= (ics > ex2 || ics < ex1) ? nearer(ics, ex1, ex2) : ics;
    ie_r <= ie_rw;
    je_r <= je_rw;
    x2_2 <= x2;
    xl_2 <= xl;
    yl_2 <= yl;
    yh_2 <= yh;
    h2_2 <= h2;
    below2 <= kcs < h2;
  end

  // Stage 3: magnitudes of the axis offsets.
  logic [MW-1:0] m_q [10];
  logic          below3;
  always_ff @(posedge clk) begin
    m_q[0] <= mag(ics - x2_2);
    m_q[1] <= mag(jcs - ie_f);
    m_q[2] <= mag(ics - xl_2);
    m_q[3] <= mag(jcs - ie_b);
    m_q[4] <= mag(ics - je_s);
    m_q[5] <= mag(jcs - yl_2);
    m_q[6] <= mag(jcs - yh_2);
    m_q[7] <= mag(ics - je_r);
    m_q[8] <= mag(jcs - ie_r);
    m_q[9] <= mag(kcs - h2_2);
    below3 <= below2;
  end

  // Stage 4: squares.
  logic [QW-1:0] sq_q [10];
  logic          below4;
  always_ff @(posedge clk) begin
    for (int n = 0; n < 10; n++) begin
      sq_q[n] <= QW'(m_q[n]) * QW'(m_q[n]);
    end
    below4 <= below3;
  end

  // Stage 5: squared distances to each face and to the roof.
  logic [SW-1:0] d_front, d_back, d_right, d_left, d_roof;
  logic          below5;
  always_ff @(posedge clk) begin
    d_front <= SW'(sq_q[0]) + SW'(sq_q[1]);
    d_back  <= SW'(sq_q[2]) + SW'(sq_q[3]);
    d_right <= SW'(sq_q[4]) + SW'(sq_q[5]);
    d_left  <= SW'(sq_q[4]) + SW'(sq_q[6]);
    d_roof  <= SW'(sq_q[7]) + SW'(sq_q[8]) + SW'(sq_q[9]);
    below5  <= below4;
  end

  // Stage 6 and 7: nearest side face, then side or roof.
  logic [SW-1:0] m_fb, m_rl, roof6;
  logic          below6;
  always_ff @(posedge clk) begin
    m_fb   <= (d_back < d_front) ? d_back : d_front;
    m_rl   <= (d_left < d_right) ? d_left : d_right;
    roof6  <= d_roof;
    below6 <= below5;
  end

  always_ff @(posedge clk) begin
    if (below6) begin
      out_dist <= (m_rl < m_fb) ? m_rl : m_fb;
    end else begin
      out_dist <= roof6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
  end

  assign out_valid = vld[6];
  assign busy = |vld;

endmodule

// ===== hw/rtl/nbd_sqrt_cell.sv =====
module nbd_sqrt_cell #(
  parameter int CW = 21
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*CW-1:0] in_rad,
  input  logic [CW+2:0]   in_rem,
  input  logic [CW-1:0]   in_root,
  output logic            out_valid,
  output logic [2*CW-1:0] out_rad,
  output logic [CW+2:0]   out_rem,
  output logic [CW-1:0]   out_root
);

  logic [CW+2:0] cur, trial;

  // Bring down the next two radicand bits and try a one digit.
  assign cur = {in_rem[CW:0], in_rad[2*CW-1 -: 2]};
  assign trial = (CW+3)'({in_root, 2'b01});

  always_ff @(posedge clk) begin
    out_rad <= {in_rad[2*CW-3:0], 2'b00};
    if (cur >= trial) begin
      out_rem  <= cur - trial;
      out_root <= {in_root[CW-2:0], 1'b1};
    end else begin
      out_rem  <= cur;
      out_root <= {in_root[CW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

// ===== hw/rtl/nbd_sqrt_chain.sv =====
module nbd_sqrt_chain
  import nbd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CW = nbd_cw(FRAC_BITS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*CW-1:0] in_rad,
  output logic            out_valid,
  output logic [CW-1:0]   out_root
);

  logic            v_c    [CW+1];
  logic [2*CW-1:0] rad_c  [CW+1];
  logic [CW+2:0]   rem_c  [CW+1];
  logic [CW-1:0]   root_c [CW+1];

  assign v_c[0]    = in_valid;
  assign rad_c[0]  = in_rad;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  // One root digit per cell, most significant first.
  for (genvar g = 0; g < CW; g++) begin : g_cell
    nbd_sqrt_cell #(.CW(CW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_c[g]),
      .in_rad    (rad_c[g]),
      .in_rem    (rem_c[g]),
      .in_root   (root_c[g]),
      .out_valid (v_c[g+1]),
      .out_rad   (rad_c[g+1]),
      .out_rem   (rem_c[g+1]),
      .out_root  (root_c[g+1])
    );
  end

  assign out_valid = v_c[CW];
  assign out_root  = root_c[CW];

endmodule
